/* rtl/core/hit_region_table_assert.svh */
// ----------------------------------------------------------------------------
// hit_region_table assertion macros
// Shared concurrent assertion forms for the region table checkers.
// ----------------------------------------------------------------------------
`ifndef HIT_REGION_TABLE_ASSERT_SVH
`define HIT_REGION_TABLE_ASSERT_SVH

// same-cycle implication
`define HRT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hrt_pkg.sv */
// ----------------------------------------------------------------------------
// hrt_pkg
// Types, codes and constants of the screen hit region table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrt_pkg;

  localparam int MAX_REGIONS_DEF = 64;
  localparam logic [11:0] COL_MAX = 12'hFFF;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_SHIFT = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_HIT     = 3'd3,
    ST_MISS    = 3'd4,
    ST_SHIFTED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] owner_id;
    logic [11:0] column;
    logic [9:0]  row;
    logic [11:0] span;
    logic [11:0] shift_amount;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] hit_owner;
    logic [11:0] hit_column;
    logic [11:0] hit_span;
    logic [5:0]  hit_slot;
  } out_item_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [11:0] column;
    logic [9:0]  row;
    logic [11:0] span;
  } entry_t;

  function automatic out_item_t make_result(status_e st);
    out_item_t r;
    r            = '0;
    r.status     = st;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hrt_mem.sv */
// ----------------------------------------------------------------------------
// hrt_mem
// Region entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrt_mem
  import hrt_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data
);

  entry_t mem [MAX_REGIONS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/hrt_seq.sv */
// ----------------------------------------------------------------------------
// hrt_seq
// Walks the entry store for add, find and shift; read, compare, write back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrt_seq
  import hrt_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  localparam int CNT_W = $clog2(MAX_REGIONS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  res_valid,
  input  wire logic             res_take,
  output out_item_t             res_data,
  output logic                  mem_rd_en,
  output logic [IDX_W-1:0]      mem_rd_addr,
  input  wire entry_t           mem_rd_data,
  output logic                  mem_wr_en,
  output logic [IDX_W-1:0]      mem_wr_addr,
  output entry_t                mem_wr_data
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REGIONS);

  seq_state_e       state_r, state_nxt;
  in_item_t         op_r, op_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             vld_r, vld_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_item_t        res_r, res_nxt;

  logic [12:0]      span_end;
  logic [12:0]      moved;
  logic             hit;

  assign span_end = {1'b0, mem_rd_data.column} + {1'b0, mem_rd_data.span};
  assign moved    = {1'b0, mem_rd_data.column} + {1'b0, op_r.shift_amount};
  assign hit      = (mem_rd_data.row == op_r.row) &&
                    (op_r.column >= mem_rd_data.column) &&
                    ({1'b0, op_r.column} < span_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    rd_idx_r  <= rd_idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    res_r     <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    rd_idx_nxt  = rd_idx_r;
    chk_idx_nxt = chk_idx_r;
    vld_nxt     = vld_r;
    count_nxt   = count_r;
    res_nxt     = res_r;
    in_ready    = (state_r == S_IDLE);
    res_valid   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_idx_r[IDX_W-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = chk_idx_r;
    mem_wr_data = mem_rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data;
          rd_idx_nxt = '0;
          vld_nxt    = 1'b0;
          if (in_data.action == ACT_NONE) begin
            res_nxt   = make_result(ST_MISS);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        vld_nxt = 1'b0;
        if (rd_idx_r < count_r) begin
          mem_rd_en   = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          vld_nxt     = 1'b1;
        end

        if (vld_r) begin
          unique case (op_r.action)
            ACT_ADD: begin
              if (mem_rd_data.owner == op_r.owner_id) begin
                res_nxt   = make_result(ST_DUP);
                state_nxt = S_DONE;
              end
            end
            ACT_FIND: begin
              if (hit) begin
                res_nxt            = make_result(ST_HIT);
                res_nxt.hit_owner  = mem_rd_data.owner;
                res_nxt.hit_column = mem_rd_data.column;
                res_nxt.hit_span   = mem_rd_data.span;
                res_nxt.hit_slot   = 6'(chk_idx_r);
                state_nxt          = S_DONE;
              end
            end
            ACT_SHIFT: begin
              if ((mem_rd_data.row == op_r.row) &&
                  (mem_rd_data.column > op_r.column)) begin
                mem_wr_en          = 1'b1;
                mem_wr_data.column = moved[12] ? COL_MAX : moved[11:0];
              end
            end
            default: ;
          endcase
        end else if (rd_idx_r == count_r) begin
          state_nxt = S_DONE;
          unique case (op_r.action)
            ACT_ADD: begin
              if (count_r == CNT_FULL) begin
                res_nxt = make_result(ST_FULL);
              end else begin
                mem_wr_en          = 1'b1;
                mem_wr_addr        = count_r[IDX_W-1:0];
                mem_wr_data.owner  = op_r.owner_id;
                mem_wr_data.column = op_r.column;
                mem_wr_data.row    = op_r.row;
                mem_wr_data.span   = op_r.span;
                count_nxt          = count_r + 1'b1;
                res_nxt            = make_result(ST_ADDED);
              end
            end
            ACT_SHIFT: res_nxt = make_result(ST_SHIFTED);
            default:   res_nxt = make_result(ST_MISS);
          endcase
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_data = res_r;

endmodule

`default_nettype wire

/* rtl/core/hit_region_table.sv */
// ----------------------------------------------------------------------------
// hit_region_table
// Screen region table: add, point lookup and row shift over stored regions.
//
//   channel | dir | beat
//   in_     | in  | in_item_t  (action, owner, column, row, span, shift)
//   out_    | out | out_item_t (status, hit owner/column/span/slot)
//
// One item at a time. An add, find or shift walks the stored regions through
// the single read port, one entry per cycle; find stops at the first hit and
// add at the first entry with the same owner. An unused action returns a miss
// without a walk.
// Shift writes back while the next entry reads.
// Reset empties the table at once; entries are undefined until written.
// The result waits in the output register; a stalled out_ stops the next item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hit_region_table
  import hrt_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  logic             res_valid;
  logic             res_take;
  out_item_t        res_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;

  logic             out_valid_r;
  out_item_t        out_data_r;

  hrt_seq #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_data   (res_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data)
  );

  hrt_mem #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_mem (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/hrt_checker.sv */
// ----------------------------------------------------------------------------
// hrt_checker
// Port-level checks on the region table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hit_region_table_assert.svh"

module hrt_checker
  import hrt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  logic out_stall;
  logic fields_zero;

  assign out_stall   = out_valid && !out_ready;
  assign fields_zero = (out_data.hit_owner == '0) && (out_data.hit_column == '0) &&
                       (out_data.hit_span == '0) && (out_data.hit_slot == '0);

  // result beat holds while stalled
  `HRT_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data), "out beat changed")

  // only a hit carries region fields
  `HRT_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && (out_data.status != ST_HIT), fields_zero, "nonzero fields")

  // one item in flight
  `HRT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "second accept")

endmodule

bind hit_region_table hrt_checker u_hrt_checker (.*);

`default_nettype wire
